### rtl/msc_pkg.sv
// shared constants, types and helpers of the matrix structure classifier
package msc_pkg;

    localparam int MAX_DIM   = 8;
    localparam int ELEM_W    = 32;
    localparam int CFG_W     = 4;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;
    localparam int POS_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIM_W     = (CFG_W > $clog2(MAX_DIM + 1)) ? CFG_W : $clog2(MAX_DIM + 1);

    // register index, taken from paddr bit 2
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    typedef logic [ELEM_W-1:0] t_elem;
    typedef logic [CFG_W-1:0]  t_cfg;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [DIM_W-1:0]  t_dim;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic zero;
        logic ident;
        logic diag;
        logic upper;
        logic lower;
        logic eqdg;
    } t_flags;

    localparam t_flags FLAGS_ALL = '{default: 1'b1};

    typedef struct packed {
        logic   is_square;
        logic   is_zero;
        logic   is_identity;
        logic   is_diagonal;
        logic   is_scalar;
        logic   is_upper;
        logic   is_lower;
        logic   is_symmetric;
    } t_result;

    typedef struct packed {
        logic   check;
        logic   last;
        logic   square;
        t_elem  value;
        t_flags flags;
    } t_stage;

    function automatic t_dim clamp_dim(input t_cfg v);
        t_dim e;
        e = DIM_W'(v);
        if (e == '0) begin
            return DIM_W'(1);
        end
        if (e > DIM_W'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end
        return e;
    endfunction

    function automatic t_addr elem_addr(input t_pos row, input t_pos col);
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col));
    endfunction

endpackage

### rtl/msc_if.sv
// request channels for matrix elements and classification results
interface msc_elem_if;
    logic            valid;
    logic            ready;
    msc_pkg::t_elem  element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface msc_result_if;
    logic valid;
    logic ready;
    logic is_square;
    logic is_zero;
    logic is_identity;
    logic is_diagonal;
    logic is_scalar;
    logic is_upper;
    logic is_lower;
    logic is_symmetric;

    modport source (
        output valid, input ready,
        output is_square, output is_zero, output is_identity, output is_diagonal,
        output is_scalar, output is_upper, output is_lower, output is_symmetric
    );
    modport sink (
        input valid, output ready,
        input is_square, input is_zero, input is_identity, input is_diagonal,
        input is_scalar, input is_upper, input is_lower, input is_symmetric
    );
endinterface

### rtl/matrix_structure_classifier.sv
// matrix structure classifier top level
//
// Takes one matrix element per cycle in row-major order while the output is
// not stalled and, after the last element of a matrix has passed the element
// stage register and the symmetry stage into the result register, presents
// one result with eight structure flags. Every element makes one write and
// one mirror read of the element store, a single memory with a registered
// read, and the symmetry check finishes in the cycle after the read. A result
// waiting on the output does not stop new elements until a second one is
// ready behind it. Row and column counts are written over the APB-style port
// at byte addresses 0 and 4; a write restarts the matrix in progress. Counts
// of zero act as one, counts above the maximum dimension saturate.
module matrix_structure_classifier (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    msc_elem_if.sink                  i_elem,
    msc_result_if.source              o_result,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [msc_pkg::APB_AW-1:0] paddr,
    input  logic [msc_pkg::APB_DW-1:0] pwdata,
    output logic [msc_pkg::APB_DW-1:0] prdata,
    output logic                      pready
);

    msc_pkg::t_cfg   r_row_count;
    msc_pkg::t_cfg   r_column_count;
    msc_pkg::t_pos   r_row;
    msc_pkg::t_pos   r_col;
    msc_pkg::t_elem  r_first;
    msc_pkg::t_flags r_flags;
    logic            r_sym;
    logic            r_s1_valid;
    msc_pkg::t_stage r_s1;
    msc_pkg::t_elem  r_mirror;
    logic            r_out_valid;
    msc_pkg::t_result r_out;

    msc_pkg::t_elem  r_store [msc_pkg::DEPTH];

    msc_pkg::t_pos   n_row;
    msc_pkg::t_pos   n_col;
    msc_pkg::t_elem  n_first;
    msc_pkg::t_flags n_flags;
    msc_pkg::t_stage n_s1;
    msc_pkg::t_result n_out;

    logic            cfg_wr;
    logic            accept;
    logic            out_free;
    logic            s1_leave;
    logic            sym_now;
    logic            restart;
    logic            square;
    msc_pkg::t_dim   nr;
    msc_pkg::t_dim   nc;
    msc_pkg::t_pos   cur_r;
    msc_pkg::t_pos   cur_c;
    msc_pkg::t_addr  wr_addr;
    msc_pkg::t_addr  rd_addr;
    msc_pkg::t_elem  v;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            msc_pkg::REG_ROW_COUNT:    prdata = msc_pkg::APB_DW'(r_row_count);
            msc_pkg::REG_COLUMN_COUNT: prdata = msc_pkg::APB_DW'(r_column_count);
            default:                   prdata = '0;
        endcase
    end

    // handshakes
    assign out_free = !r_out_valid || o_result.ready;
    assign s1_leave = r_s1_valid && (!r_s1.last || out_free);
    assign i_elem.ready = !r_s1_valid || s1_leave;
    assign accept = i_elem.valid && i_elem.ready;
    assign v = i_elem.element_value;

    // element stage
    always_comb begin
        msc_pkg::t_flags f;
        logic            last;
        nr = msc_pkg::clamp_dim(r_row_count);
        nc = msc_pkg::clamp_dim(r_column_count);
        square = (nr == nc);
        restart = (msc_pkg::DIM_W'(r_row) >= nr) || (msc_pkg::DIM_W'(r_col) >= nc);
        cur_r = restart ? '0 : r_row;
        cur_c = restart ? '0 : r_col;
        f = restart ? msc_pkg::FLAGS_ALL : r_flags;
        n_first = restart ? '0 : r_first;
        if (v != '0) begin
            f.zero = 1'b0;
        end
        if (cur_r == cur_c) begin
            if (v != msc_pkg::ELEM_W'(1)) begin
                f.ident = 1'b0;
            end
            if (cur_r == '0) begin
                n_first = v;
            end else if (v != n_first) begin
                f.eqdg = 1'b0;
            end
        end else if (v != '0) begin
            f.ident = 1'b0;
            f.diag = 1'b0;
            if (cur_r > cur_c) begin
                f.upper = 1'b0;
            end else begin
                f.lower = 1'b0;
            end
        end
        last = (msc_pkg::DIM_W'(cur_r) + msc_pkg::DIM_W'(1) == nr)
            && (msc_pkg::DIM_W'(cur_c) + msc_pkg::DIM_W'(1) == nc);
        n_s1.check = square && (cur_r > cur_c);
        n_s1.last = last;
        n_s1.square = square;
        n_s1.value = v;
        n_s1.flags = f;
        if (last) begin
            n_flags = msc_pkg::FLAGS_ALL;
            n_first = '0;
            n_row = '0;
            n_col = '0;
        end else begin
            n_flags = f;
            if (msc_pkg::DIM_W'(cur_c) + msc_pkg::DIM_W'(1) >= nc) begin
                n_col = '0;
                n_row = msc_pkg::POS_W'(cur_r + msc_pkg::POS_W'(1));
            end else begin
                n_col = msc_pkg::POS_W'(cur_c + msc_pkg::POS_W'(1));
                n_row = cur_r;
            end
        end
        wr_addr = msc_pkg::elem_addr(cur_r, cur_c);
        rd_addr = msc_pkg::elem_addr(cur_c, cur_r);
    end

    // element store, write and mirror read per element
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_store[wr_addr] <= v;
            r_mirror <= r_store[rd_addr];
        end
    end

    // symmetry stage and result
    always_comb begin
        sym_now = r_sym && !(r_s1.check && (r_mirror != r_s1.value));
        n_out.is_square    = r_s1.square;
        n_out.is_zero      = r_s1.flags.zero;
        n_out.is_identity  = r_s1.flags.ident;
        n_out.is_diagonal  = r_s1.flags.diag;
        n_out.is_scalar    = r_s1.square && r_s1.flags.diag && r_s1.flags.eqdg;
        n_out.is_upper     = r_s1.flags.upper;
        n_out.is_lower     = r_s1.flags.lower;
        n_out.is_symmetric = r_s1.square && sym_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= msc_pkg::CFG_W'(1);
            r_column_count <= msc_pkg::CFG_W'(1);
            r_row <= '0;
            r_col <= '0;
            r_first <= '0;
            r_flags <= msc_pkg::FLAGS_ALL;
            r_sym <= 1'b1;
            r_s1_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    msc_pkg::REG_ROW_COUNT:    r_row_count <= pwdata[msc_pkg::CFG_W-1:0];
                    msc_pkg::REG_COLUMN_COUNT: r_column_count <= pwdata[msc_pkg::CFG_W-1:0];
                    default:                   r_row_count <= r_row_count;
                endcase
                r_row <= '0;
                r_col <= '0;
                r_first <= '0;
                r_flags <= msc_pkg::FLAGS_ALL;
                r_sym <= 1'b1;
            end else begin
                if (accept) begin
                    r_row <= n_row;
                    r_col <= n_col;
                    r_first <= n_first;
                    r_flags <= n_flags;
                end
                if (s1_leave) begin
                    r_sym <= r_s1.last ? 1'b1 : sym_now;
                end
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_leave) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_leave && r_s1.last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (s1_leave && r_s1.last) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.is_square    = r_out.is_square;
    assign o_result.is_zero      = r_out.is_zero;
    assign o_result.is_identity  = r_out.is_identity;
    assign o_result.is_diagonal  = r_out.is_diagonal;
    assign o_result.is_scalar    = r_out.is_scalar;
    assign o_result.is_upper     = r_out.is_upper;
    assign o_result.is_lower     = r_out.is_lower;
    assign o_result.is_symmetric = r_out.is_symmetric;

endmodule
